// ===== sv/shash_pkg.sv =====
// Package for the SHA-256 stream hasher: item and queue entry types, state encodings,
// round constants, initial hash values and the sigma helper functions.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package shash_pkg;

  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  data_byte;
    logic [31:0] byte_len;
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } core_state_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LAST_FILL  = 6'd63;
  localparam logic [5:0] LEN_FILL   = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  localparam logic [31:0] IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/sha256_stream_hasher.sv =====
// SHA-256 stream hasher. The core takes one absorb item per cycle while idle; every 64th byte
// starts a compression of 64 rounds, at one per cycle in the single round unit, then one
// chaining add, during which the core takes no items.
// A finish item pads the block (adding a length block when 56 or more bytes are pending)
// and then the eight digest words follow, one word per cycle while they are taken.
// Synchronous reset loads the initial hash values and zeroes the byte count; no clearing pass.
`default_nettype none

module sha256_stream_hasher
  import shash_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic push_valid;
  logic push_ready;
  op_t  push_data;
  logic pop_valid;
  logic pop_ready;
  op_t  pop_data;

  shash_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  shash_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  shash_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (pop_valid),
    .op_ready  (pop_ready),
    .op_data   (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== sv/shash_front.sv =====
// Front end of the SHA-256 stream hasher: accepts input items, keeps the message
// byte count and tags each item with it before it enters the queue.
// Depends on shash_pkg.
`default_nettype none

module shash_front
  import shash_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          push_valid,
  input  wire logic     push_ready,
  output op_t           push_data
);

  logic [31:0] len_r;
  logic [31:0] len_nxt;
  logic        accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    push_data.command   = in_item.command;
    push_data.data_byte = in_item.data_byte;
    push_data.byte_len  = len_r;
    if (in_item.command == CMD_FINISH) begin
      len_nxt = 32'd0;
    end else begin
      len_nxt = len_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 32'd0;
    end else if (accept) begin
      len_r <= len_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/shash_queue.sv =====
// Short queue of tagged items between the front end and the compression core
// of the SHA-256 stream hasher, so that each side can stall on its own.
// Depends on shash_pkg.
`default_nettype none

module shash_queue
  import shash_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire op_t  push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output op_t       pop_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  op_t             entry_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != FullCnt);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/shash_core.sv =====
// Back end of the SHA-256 stream hasher: block buffer and message schedule, the
// one-round-per-cycle compression unit, padding, chaining state and digest output.
// Depends on shash_pkg.
`default_nettype none

module shash_core
  import shash_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  op_valid,
  output logic       op_ready,
  input  wire op_t   op_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_item
);

  core_state_t state_r;
  core_state_t state_nxt;

  logic [31:0] win_r   [16];
  logic [31:0] var_r   [8];
  logic [31:0] chain_r [8];
  logic [31:0] len_r;
  logic [5:0]  rnd_r;
  logic [2:0]  idx_r;
  logic        fin_r;
  logic        second_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic        op_pop;
  logic        out_load;
  logic        out_free;
  logic [5:0]  fill;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic [31:0] sum     [8];
  logic [31:0] pad_win [16];
  logic [31:0] len_win [16];
  logic [31:0] op_bits_hi;
  logic [31:0] op_bits_lo;

  assign fill      = op_data.byte_len[5:0];
  assign out_free  = !out_valid_r || out_ready;
  assign op_ready  = op_pop;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt = state_r;
    op_pop    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          op_pop = 1'b1;
          if (op_data.command == CMD_FINISH || fill == LAST_FILL) begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (second_r) begin
          state_nxt = ST_ROUND;
        end else if (fin_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (idx_r == LAST_WORD) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    t1 = var_r[7] + big_s1(var_r[4]) + ((var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]))
       + ROUND_K[rnd_r] + win_r[0];
    t2 = big_s0(var_r[0]) + ((var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2])
       ^ (var_r[1] & var_r[2]));
    w_new = small_s1(win_r[14]) + win_r[9] + small_s0(win_r[1]) + win_r[0];
    for (int j = 0; j < 8; j++) begin
      sum[j] = chain_r[j] + var_r[j];
    end
  end

  // The closing block: bytes below the fill point are kept, the fill point gets the
  // pad marker and the rest is zero; the length goes in when it still fits.
  always_comb begin
    op_bits_hi = {29'd0, op_data.byte_len[31:29]};
    op_bits_lo = {op_data.byte_len[28:0], 3'b000};
    for (int i = 0; i < 16; i++) begin
      for (int b = 0; b < 4; b++) begin
        if (6'(4 * i + b) < fill) begin
          pad_win[i][8*(3-b) +: 8] = win_r[i][8*(3-b) +: 8];
        end else if (6'(4 * i + b) == fill) begin
          pad_win[i][8*(3-b) +: 8] = PAD_BYTE;
        end else begin
          pad_win[i][8*(3-b) +: 8] = 8'd0;
        end
      end
      len_win[i] = 32'd0;
    end
    if (fill < LEN_FILL) begin
      pad_win[14] = op_bits_hi;
      pad_win[15] = op_bits_lo;
    end
    len_win[14] = {29'd0, len_r[31:29]};
    len_win[15] = {len_r[28:0], 3'b000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 8; j++) begin
        chain_r[j] <= IV[j];
      end
      rnd_r       <= '0;
      idx_r       <= '0;
      fin_r       <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          rnd_r <= '0;
          if (op_pop && op_data.command == CMD_FINISH) begin
            fin_r    <= 1'b1;
            second_r <= (fill >= LEN_FILL);
          end
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
        end
        ST_UPDATE: begin
          for (int j = 0; j < 8; j++) begin
            chain_r[j] <= sum[j];
          end
          second_r <= 1'b0;
          rnd_r    <= '0;
        end
        ST_EMIT: begin
          if (out_load) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == LAST_WORD) begin
              fin_r <= 1'b0;
              for (int j = 0; j < 8; j++) begin
                chain_r[j] <= IV[j];
              end
            end
          end
        end
        default: begin
          rnd_r <= '0;
        end
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (op_pop) begin
          for (int j = 0; j < 8; j++) begin
            var_r[j] <= chain_r[j];
          end
          if (op_data.command == CMD_FINISH) begin
            win_r <= pad_win;
            len_r <= op_data.byte_len;
          end else begin
            win_r[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= op_data.data_byte;
          end
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[15] <= w_new;
        var_r[7]  <= var_r[6];
        var_r[6]  <= var_r[5];
        var_r[5]  <= var_r[4];
        var_r[4]  <= var_r[3] + t1;
        var_r[3]  <= var_r[2];
        var_r[2]  <= var_r[1];
        var_r[1]  <= var_r[0];
        var_r[0]  <= t1 + t2;
      end
      ST_UPDATE: begin
        for (int j = 0; j < 8; j++) begin
          var_r[j] <= sum[j];
        end
        if (second_r) begin
          win_r <= len_win;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_r.digest_word <= chain_r[idx_r];
      out_r.word_index  <= idx_r;
      out_r.last        <= (idx_r == LAST_WORD);
    end
  end

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == LAST_ROUND) |=> state_r == ST_UPDATE)
    else $error("compression did not end after the last round");

  a_second_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> fin_r)
    else $error("length block pending outside a finish");

  a_emit_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && fin_r && !second_r) |=> state_r == ST_EMIT)
    else $error("digest not emitted after the final block");

  a_chain_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && idx_r == LAST_WORD) |=>
      (state_r == ST_IDLE && !fin_r && chain_r[0] == IV[0] && chain_r[7] == IV[7]))
    else $error("chaining state not restored after the last digest word");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !op_ready)
    else $error("item taken while a block is in progress");

endmodule

`default_nettype wire
